// ----- rtl/efsd_pkg.sv -----
// Shared types and constants for the earliest-free-server dispatch block.
`default_nettype none
package efsd_pkg;

  localparam int MAX_WINDOWS = 16;
  localparam int WIN_IDX_W   = $clog2(MAX_WINDOWS);
  localparam int WIN_CNT_W   = 5;
  localparam int SEC_W       = 17;
  localparam int MIN_W       = 10;
  localparam int TIME_W      = 32;
  localparam int TOTAL_W     = 48;
  localparam int COUNT_W     = 32;
  localparam int SVC_SEC_W   = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 17;

  localparam logic [5:0]           SEC_PER_MIN       = 6'd60;
  localparam logic [WIN_CNT_W-1:0] RST_WINDOW_COUNT  = 5'd1;
  localparam logic [SEC_W-1:0]     RST_OPEN_TIME     = 17'd28800;
  localparam logic [SEC_W-1:0]     RST_LAST_ARRIVAL  = 17'd61200;
  localparam logic [MIN_W-1:0]     RST_MAX_SVC_MIN   = 10'd60;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_TIME     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_ARRIVAL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SVC_MIN   = 3'd3;

  typedef struct packed {
    logic [SEC_W-1:0] arrival_seconds;
    logic [MIN_W-1:0] service_minutes;
  } cust_t;

  typedef struct packed {
    logic               served;
    logic [3:0]         window_chosen;
    logic [TIME_W-1:0]  wait_seconds;
    logic [TOTAL_W-1:0] total_wait_seconds;
    logic [COUNT_W-1:0] served_count;
  } disp_t;

  typedef struct packed {
    logic [WIN_CNT_W-1:0] window_count;
    logic [SEC_W-1:0]     open_time;
    logic [SEC_W-1:0]     last_arrival;
    logic [MIN_W-1:0]     max_service_minutes;
  } cfg_t;

  typedef struct packed {
    logic [WIN_IDX_W-1:0] rd_addr;
    logic                 wr_en;
    logic [WIN_IDX_W-1:0] wr_addr;
    logic [TIME_W-1:0]    wr_data;
    logic                 reload;
  } mem_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CALC,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/efsd_free_mem.sv -----
// Window free-time memory with per-entry valid bits; invalid entries read as open time.
`default_nettype none
module efsd_free_mem (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire efsd_pkg::mem_cmd_t               cmd,
  input  wire logic [efsd_pkg::SEC_W-1:0]       open_time,
  output logic      [efsd_pkg::TIME_W-1:0]      rd_time
);

  logic [efsd_pkg::TIME_W-1:0]    mem [efsd_pkg::MAX_WINDOWS];
  logic [efsd_pkg::MAX_WINDOWS-1:0] entry_valid;
  logic [efsd_pkg::TIME_W-1:0]    rd_raw;
  logic                           rd_valid;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= cmd.wr_data;
    end
    rd_raw <= mem[cmd.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.reload) begin
      entry_valid <= '0;
      rd_valid    <= 1'b0;
    end else begin
      if (cmd.wr_en) begin
        entry_valid[cmd.wr_addr] <= 1'b1;
      end
      rd_valid <= entry_valid[cmd.rd_addr];
    end
  end

  assign rd_time = rd_valid ? rd_raw
                 : {{(efsd_pkg::TIME_W-efsd_pkg::SEC_W){1'b0}}, open_time};

endmodule
`default_nettype wire

// ----- rtl/efsd_engine.sv -----
// Dispatch sequencer: scans free times, assigns a window, keeps totals, holds the result.
`default_nettype none
module efsd_engine (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire efsd_pkg::cfg_t              cfg,
  input  wire logic                        cust_valid,
  output logic                             cust_stall,
  input  wire efsd_pkg::cust_t             cust,
  output logic                             disp_valid,
  input  wire logic                        disp_stall,
  output efsd_pkg::disp_t                  disp,
  output efsd_pkg::mem_cmd_t               mem_cmd,
  input  wire logic [efsd_pkg::TIME_W-1:0] rd_time
);

  efsd_pkg::state_t state, state_next;

  logic [efsd_pkg::SEC_W-1:0]     arrival;
  logic [efsd_pkg::MIN_W-1:0]     minutes;
  logic [efsd_pkg::WIN_IDX_W-1:0] scan_idx;
  logic [efsd_pkg::WIN_IDX_W-1:0] last_idx;
  logic [efsd_pkg::WIN_IDX_W-1:0] best_idx;
  logic [efsd_pkg::TIME_W-1:0]    best_time;
  logic [efsd_pkg::TOTAL_W-1:0]   wait_total;
  logic [efsd_pkg::COUNT_W-1:0]   customer_total;
  efsd_pkg::disp_t                res;

  logic                           accept;
  logic                           late;
  logic                           slot_free;
  logic [efsd_pkg::MIN_W-1:0]     min_clamped;
  logic [efsd_pkg::TIME_W-1:0]    arrival_ext;
  logic [efsd_pkg::TIME_W-1:0]    start;
  logic [efsd_pkg::TIME_W-1:0]    wait_sec;
  logic [efsd_pkg::SVC_SEC_W-1:0] svc_sec;
  logic [efsd_pkg::TIME_W:0]      finish_sum;
  logic [efsd_pkg::TIME_W-1:0]    finish;
  logic [efsd_pkg::TOTAL_W:0]     total_sum;
  logic [efsd_pkg::TOTAL_W-1:0]   total_sat;
  logic [efsd_pkg::COUNT_W-1:0]   count_inc;
  logic [efsd_pkg::WIN_IDX_W-1:0] last_idx_cfg;

  assign accept    = cust_valid && !cust_stall;
  assign late      = cust.arrival_seconds > cfg.last_arrival;
  assign slot_free = !disp_valid || !disp_stall;

  assign min_clamped = (cust.service_minutes > cfg.max_service_minutes)
                       ? cfg.max_service_minutes : cust.service_minutes;

  always_comb begin
    if (cfg.window_count == '0) begin
      last_idx_cfg = '0;
    end else if (cfg.window_count > efsd_pkg::WIN_CNT_W'(efsd_pkg::MAX_WINDOWS)) begin
      last_idx_cfg = efsd_pkg::WIN_IDX_W'(efsd_pkg::MAX_WINDOWS - 1);
    end else begin
      last_idx_cfg = efsd_pkg::WIN_IDX_W'(cfg.window_count - 5'd1);
    end
  end

  assign arrival_ext = {{(efsd_pkg::TIME_W-efsd_pkg::SEC_W){1'b0}}, arrival};
  assign start       = (best_time > arrival_ext) ? best_time : arrival_ext;
  assign wait_sec    = (best_time > arrival_ext) ? (best_time - arrival_ext) : '0;
  assign svc_sec     = efsd_pkg::SVC_SEC_W'(minutes * efsd_pkg::SEC_PER_MIN);
  assign finish_sum  = {1'b0, start}
                     + {{(efsd_pkg::TIME_W+1-efsd_pkg::SVC_SEC_W){1'b0}}, svc_sec};
  assign finish      = finish_sum[efsd_pkg::TIME_W] ? '1
                     : finish_sum[efsd_pkg::TIME_W-1:0];
  assign total_sum   = {1'b0, wait_total}
                     + {{(efsd_pkg::TOTAL_W+1-efsd_pkg::TIME_W){1'b0}}, wait_sec};
  assign total_sat   = total_sum[efsd_pkg::TOTAL_W] ? '1
                     : total_sum[efsd_pkg::TOTAL_W-1:0];
  assign count_inc   = (customer_total == '1) ? customer_total
                     : customer_total + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= efsd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    cust_stall      = 1'b1;
    mem_cmd.rd_addr = scan_idx + 1'b1;
    mem_cmd.wr_en   = 1'b0;
    mem_cmd.wr_addr = best_idx;
    mem_cmd.wr_data = finish;
    mem_cmd.reload  = 1'b0;
    unique case (state)
      efsd_pkg::ST_IDLE: begin
        cust_stall      = rst;
        mem_cmd.rd_addr = '0;
        if (cust_valid) begin
          state_next = late ? efsd_pkg::ST_DONE : efsd_pkg::ST_SCAN;
        end
      end
      efsd_pkg::ST_SCAN: begin
        if (scan_idx == last_idx) begin
          state_next = efsd_pkg::ST_CALC;
        end
      end
      efsd_pkg::ST_CALC: begin
        mem_cmd.wr_en = 1'b1;
        state_next    = efsd_pkg::ST_DONE;
      end
      efsd_pkg::ST_DONE: begin
        if (slot_free) begin
          state_next = efsd_pkg::ST_IDLE;
        end
      end
      default: state_next = efsd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      arrival  <= cust.arrival_seconds;
      minutes  <= min_clamped;
      last_idx <= last_idx_cfg;
      scan_idx <= '0;
      res      <= '{served: 1'b0, window_chosen: '0, wait_seconds: '0,
                    total_wait_seconds: wait_total, served_count: customer_total};
    end
    if (state == efsd_pkg::ST_SCAN) begin
      scan_idx <= scan_idx + 1'b1;
      if (scan_idx == '0 || rd_time < best_time) begin
        best_time <= rd_time;
        best_idx  <= scan_idx;
      end
    end
    if (state == efsd_pkg::ST_CALC) begin
      res <= '{served: 1'b1, window_chosen: 4'(best_idx), wait_seconds: wait_sec,
               total_wait_seconds: total_sat, served_count: count_inc};
    end
    if (state == efsd_pkg::ST_DONE && slot_free) begin
      disp <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_total     <= '0;
      customer_total <= '0;
      disp_valid     <= 1'b0;
    end else begin
      if (state == efsd_pkg::ST_CALC) begin
        wait_total     <= total_sat;
        customer_total <= count_inc;
      end
      if (state == efsd_pkg::ST_DONE && slot_free) begin
        disp_valid <= 1'b1;
      end else if (!disp_stall) begin
        disp_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/earliest_free_server_dispatch.sv -----
// Top level: configuration registers, free-time memory and dispatch sequencer.
//
//   channel  direction  handshake             payload
//   cust     in         cust_valid/cust_stall cust (arrival_seconds, service_minutes)
//   disp     out        disp_valid/disp_stall disp (served .. served_count)
//   cfg      in         cfg_valid/cfg_ready   cfg_index, cfg_data
//
// A served customer is accepted in idle, reads the free-time memory once per window in
// use, writes its finish time in the calc state and is handed off in the done state; no
// customer is taken until idle again; a late one goes straight to done. Reset clears
// totals and valid bits; no clearing pass is needed. Both inputs stall during reset.
// A stalled result waits in the output register while the next customer is accepted
// and scanned; the next hand-off holds until that register is free.
`default_nettype none
module earliest_free_server_dispatch (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cust_valid,
  output logic                                     cust_stall,
  input  wire efsd_pkg::cust_t                     cust,
  output logic                                     disp_valid,
  input  wire logic                                disp_stall,
  output efsd_pkg::disp_t                          disp,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [efsd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [efsd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  efsd_pkg::cfg_t     cfg;
  efsd_pkg::mem_cmd_t eng_cmd;
  efsd_pkg::mem_cmd_t mem_cmd;
  logic [efsd_pkg::TIME_W-1:0] rd_time;
  logic cfg_wr;

  assign cfg_ready = !rst;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_count        <= efsd_pkg::RST_WINDOW_COUNT;
      cfg.open_time           <= efsd_pkg::RST_OPEN_TIME;
      cfg.last_arrival        <= efsd_pkg::RST_LAST_ARRIVAL;
      cfg.max_service_minutes <= efsd_pkg::RST_MAX_SVC_MIN;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        efsd_pkg::REG_WINDOW_COUNT: cfg.window_count <= cfg_data[efsd_pkg::WIN_CNT_W-1:0];
        efsd_pkg::REG_OPEN_TIME:    cfg.open_time    <= cfg_data[efsd_pkg::SEC_W-1:0];
        efsd_pkg::REG_LAST_ARRIVAL: cfg.last_arrival <= cfg_data[efsd_pkg::SEC_W-1:0];
        efsd_pkg::REG_MAX_SVC_MIN:  cfg.max_service_minutes <= cfg_data[efsd_pkg::MIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    mem_cmd        = eng_cmd;
    mem_cmd.reload = cfg_wr && (cfg_index == efsd_pkg::REG_OPEN_TIME);
  end

  efsd_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cust_valid (cust_valid),
    .cust_stall (cust_stall),
    .cust       (cust),
    .disp_valid (disp_valid),
    .disp_stall (disp_stall),
    .disp       (disp),
    .mem_cmd    (eng_cmd),
    .rd_time    (rd_time)
  );

  efsd_free_mem u_free_mem (
    .clk       (clk),
    .rst       (rst),
    .cmd       (mem_cmd),
    .open_time (cfg.open_time),
    .rd_time   (rd_time)
  );

endmodule
`default_nettype wire
